@@ design/offset_to_line_column_map_defines.svh @@
// Assertion macros used by the offset-to-line/column map top level.
`ifndef OFFSET_TO_LINE_COLUMN_MAP_DEFINES_SVH
`define OFFSET_TO_LINE_COLUMN_MAP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OTLC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("otlc assertion failed");
// next-cycle implication
`define OTLC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("otlc assertion failed");
`else
`define OTLC_ASSERT_NOW(label, clk, rst, pre, post)
`define OTLC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

@@ design/otlc_pkg.sv @@
// Shared constants and types of the offset-to-line/column map.
package otlc_pkg;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_BITS = 20;
   localparam int QFILE_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int FILE_IDX_W  = 4;
   localparam int LINE_W      = 13;
   localparam int COL_W       = 21;

   localparam int DEF_MAX_FILES = 16;
   localparam int DEF_MAX_LINES = 4096;

   // file sizes and line starts can reach 2^OFFSET_BITS
   localparam int SZ_W  = OFFSET_BITS + 1;
   localparam int CMP_W = OFFSET_BITS + 2;

   localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_BYTE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_BASE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

   typedef struct packed {
      logic             ge;      // x >= lo
      logic             lt_end;  // x < lo + len
      logic [CMP_W-1:0] diff;    // x - lo
   } cmp_result_type;

endpackage

@@ design/otlc_ifs.sv @@
// Request and response channel interfaces of the offset-to-line/column map.
interface otlc_req_if import otlc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_W-1:0]    opcode;
   logic [BYTE_W-1:0]      data_byte;
   logic [OFFSET_BITS-1:0] query_offset;
   logic [QFILE_W-1:0]     query_file;

   modport source (output valid, opcode, data_byte, query_offset, query_file,
                   input ready);
   modport sink   (input valid, opcode, data_byte, query_offset, query_file,
                   output ready);
endinterface

interface otlc_rsp_if import otlc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [FILE_IDX_W-1:0]  file_index;
   logic [LINE_W-1:0]      line_number;
   logic [COL_W-1:0]       column_number;
   logic [OFFSET_BITS-1:0] start_offset;
   logic                   overflow;

   modport source (output valid, status, file_index, line_number, column_number,
                   start_offset, overflow, input ready);
   modport sink   (input valid, status, file_index, line_number, column_number,
                   start_offset, overflow, output ready);
endinterface

@@ design/otlc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module otlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/otlc_cmp_unit.sv @@
// Shared range compare and subtract unit used by the scan and the line search.
module otlc_cmp_unit import otlc_pkg::*; (
   input  logic [CMP_W-1:0] x,
   input  logic [CMP_W-1:0] lo,
   input  logic [CMP_W-1:0] len,
   output cmp_result_type   result
);

   logic [CMP_W-1:0] hi;

   always_comb begin
      hi            = lo + len;
      result.ge     = (x >= lo);
      result.lt_end = (x < hi);
      result.diff   = x - lo;
   end

endmodule

@@ design/offset_to_line_column_map.sv @@
// Offset-to-line/column map over concatenated source files: top level.
//
// req_ch carries one transaction per operation: start file, content byte,
// lookup of a global offset, or query of a file's base offset. rsp_ch returns
// one transaction for every operation except a content byte.
// A content byte is accepted back to back.
// A start file, a table-full start and an out-of-range lookup or base query
// go from idle straight to the emit state; a valid base query passes through
// S_BASE first, since it reads the file table.
// A lookup scans the file table entry by entry (file table read then the
// shared comparator), then runs a binary search over the line start store
// (line start read then the comparator, up to log2(MAX_LINES)+1 steps) and
// then emits. The single shared comparator and the registered table reads
// set this read-then-check order.
// The block takes no new request while an operation is in progress.
// Reset clears the file count, line count, byte total, overflow flag and the
// response valid flag; the tables need no clearing pass.
// A stalled response holds in its register; a finished operation waits for
// that register to drain before the block returns to idle.
module offset_to_line_column_map import otlc_pkg::*; #(
   parameter int MAX_FILES = DEF_MAX_FILES,
   parameter int MAX_LINES = DEF_MAX_LINES
) (
   input  logic       clock,
   input  logic       reset,
   otlc_req_if.sink   req_ch,
   otlc_rsp_if.source rsp_ch
);

`include "offset_to_line_column_map_defines.svh"

   localparam int FI_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int FU_W  = $clog2(MAX_FILES + 1);
   localparam int LI_W  = $clog2(MAX_LINES);
   localparam int LU_W  = $clog2(MAX_LINES + 1);
   localparam int LT_W  = $clog2(MAX_LINES + 2);
   localparam int LA_W  = LT_W + 1;
   localparam int QX_W  = FU_W + QFILE_W;
   localparam int FE_W  = OFFSET_BITS + SZ_W + LU_W + LT_W;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_CHK = 7'b0000100,
      S_BS_RD    = 7'b0001000,
      S_BS_CHK   = 7'b0010000,
      S_BASE     = 7'b0100000,
      S_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [FU_W-1:0]        files_used_ff, files_used_in;
   logic [LU_W-1:0]        lines_used_ff, lines_used_in;
   logic [OFFSET_BITS:0]   total_ff, total_in;
   logic                   overflow_ff, overflow_in;

   // newest file, mirrored in the file table
   logic [OFFSET_BITS-1:0] cur_start_ff, cur_start_in;
   logic [SZ_W-1:0]        cur_size_ff, cur_size_in;
   logic [LU_W-1:0]        cur_first_ff, cur_first_in;
   logic [LT_W-1:0]        cur_total_ff, cur_total_in;

   logic [OFFSET_BITS-1:0] qoff_ff, qoff_in;
   logic [FI_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [OFFSET_BITS-1:0] local_ff, local_in;
   logic [LU_W-1:0]        first_ff, first_in;
   logic [LT_W-1:0]        low_ff, low_in;
   logic [LT_W-1:0]        high_ff, high_in;
   logic [LT_W-1:0]        idx_ff, idx_in;
   logic [LT_W-1:0]        mid_ff, mid_in;
   logic [COL_W-1:0]       col_ff, col_in;

   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [FILE_IDX_W-1:0]  res_fidx_ff, res_fidx_in;
   logic [LINE_W-1:0]      res_line_ff, res_line_in;
   logic [COL_W-1:0]       res_col_ff, res_col_in;
   logic [OFFSET_BITS-1:0] res_base_ff, res_base_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [FILE_IDX_W-1:0]  rsp_fidx_ff;
   logic [LINE_W-1:0]      rsp_line_ff;
   logic [COL_W-1:0]       rsp_col_ff;
   logic [OFFSET_BITS-1:0] rsp_base_ff;
   logic                   rsp_ovf_ff;
   logic                   rsp_load;

   // file table
   logic              ft_wr_en;
   logic [FI_W-1:0]   ft_wr_addr;
   logic [FE_W-1:0]   ft_wr_data;
   logic [FI_W-1:0]   ft_rd_addr;
   logic [FE_W-1:0]   ft_rd_data;
   logic [OFFSET_BITS-1:0] ft_start;
   logic [SZ_W-1:0]   ft_size;
   logic [LU_W-1:0]   ft_first;
   logic [LT_W-1:0]   ft_total;

   // line start store
   logic              ln_wr_en;
   logic [LI_W-1:0]   ln_wr_addr;
   logic [SZ_W-1:0]   ln_wr_data;
   logic [LI_W-1:0]   ln_rd_addr;
   logic [SZ_W-1:0]   ln_rd_data;

   logic [CMP_W-1:0]  cmp_x, cmp_lo, cmp_len;
   cmp_result_type    cmp_res;

   logic              req_take;
   logic [SZ_W-1:0]   size_inc;
   logic [LT_W-1:0]   mid_w;
   logic [LA_W-1:0]   line_addr;
   logic              line_in_range;

   assign ft_total = ft_rd_data[LT_W-1:0];
   assign ft_first = ft_rd_data[LT_W +: LU_W];
   assign ft_size  = ft_rd_data[LT_W+LU_W +: SZ_W];
   assign ft_start = ft_rd_data[LT_W+LU_W+SZ_W +: OFFSET_BITS];

   otlc_ram #(.WIDTH(FE_W), .DEPTH(MAX_FILES)) u_file_tab (
      .clock   (clock),
      .wr_en   (ft_wr_en),
      .wr_addr (ft_wr_addr),
      .wr_data (ft_wr_data),
      .rd_addr (ft_rd_addr),
      .rd_data (ft_rd_data)
   );

   otlc_ram #(.WIDTH(SZ_W), .DEPTH(MAX_LINES)) u_line_tab (
      .clock   (clock),
      .wr_en   (ln_wr_en),
      .wr_addr (ln_wr_addr),
      .wr_data (ln_wr_data),
      .rd_addr (ln_rd_addr),
      .rd_data (ln_rd_data)
   );

   otlc_cmp_unit u_cmp (
      .x      (cmp_x),
      .lo     (cmp_lo),
      .len    (cmp_len),
      .result (cmp_res)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && (state_ff == S_IDLE);
   assign rsp_load     = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   assign size_inc  = cur_size_ff + SZ_W'(1);
   assign mid_w     = low_ff + LT_W'((high_ff - low_ff) >> 1);
   assign line_addr = LA_W'(first_ff) + LA_W'(mid_w) - LA_W'(1);
   assign line_in_range = (mid_w != '0) && (line_addr < LA_W'(MAX_LINES));

   assign ln_rd_addr = line_addr[LI_W-1:0];
   assign ft_rd_addr = (state_ff == S_IDLE) ? FI_W'(req_ch.query_file) : scan_idx_ff;

   always_comb begin
      if (state_ff == S_SCAN_CHK) begin
         cmp_x   = CMP_W'(qoff_ff);
         cmp_lo  = CMP_W'(ft_start);
         cmp_len = CMP_W'(ft_size);
      end else begin
         cmp_x   = CMP_W'(local_ff);
         cmp_lo  = CMP_W'(ln_rd_data);
         cmp_len = '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      files_used_in = files_used_ff;
      lines_used_in = lines_used_ff;
      total_in      = total_ff;
      overflow_in   = overflow_ff;
      cur_start_in  = cur_start_ff;
      cur_size_in   = cur_size_ff;
      cur_first_in  = cur_first_ff;
      cur_total_in  = cur_total_ff;
      qoff_in       = qoff_ff;
      scan_idx_in   = scan_idx_ff;
      local_in      = local_ff;
      first_in      = first_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      idx_in        = idx_ff;
      mid_in        = mid_ff;
      col_in        = col_ff;
      res_status_in = res_status_ff;
      res_fidx_in   = res_fidx_ff;
      res_line_in   = res_line_ff;
      res_col_in    = res_col_ff;
      res_base_in   = res_base_ff;
      ft_wr_en      = 1'b0;
      ft_wr_addr    = files_used_ff[FI_W-1:0];
      ft_wr_data    = '0;
      ln_wr_en      = 1'b0;
      ln_wr_addr    = lines_used_ff[LI_W-1:0];
      ln_wr_data    = size_inc;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_status_in = STATUS_NOT_FOUND;
               res_fidx_in   = '0;
               res_line_in   = '0;
               res_col_in    = '0;
               res_base_in   = '0;
               case (req_ch.opcode)
                  OP_START: begin
                     state_in = S_EMIT;
                     if (files_used_ff >= FU_W'(MAX_FILES)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        ft_wr_en      = 1'b1;
                        ft_wr_data    = {total_ff[OFFSET_BITS-1:0], SZ_W'(0),
                                         lines_used_ff, LT_W'(1)};
                        cur_start_in  = total_ff[OFFSET_BITS-1:0];
                        cur_size_in   = '0;
                        cur_first_in  = lines_used_ff;
                        cur_total_in  = LT_W'(1);
                        files_used_in = files_used_ff + FU_W'(1);
                        res_status_in = STATUS_OK;
                        res_fidx_in   = FILE_IDX_W'(files_used_ff);
                        res_base_in   = total_ff[OFFSET_BITS-1:0];
                     end
                  end
                  OP_BYTE: begin
                     if (files_used_ff == '0 || total_ff[OFFSET_BITS]) begin
                        overflow_in = 1'b1;
                     end else begin
                        cur_size_in = size_inc;
                        total_in    = total_ff + (OFFSET_BITS+1)'(1);
                        if (req_ch.data_byte == NEWLINE_BYTE) begin
                           if (lines_used_ff < LU_W'(MAX_LINES)) begin
                              ln_wr_en      = 1'b1;
                              lines_used_in = lines_used_ff + LU_W'(1);
                              cur_total_in  = cur_total_ff + LT_W'(1);
                           end else begin
                              overflow_in = 1'b1;
                           end
                        end
                        // rewrite the newest file's entry
                        ft_wr_en   = 1'b1;
                        ft_wr_addr = FI_W'(files_used_ff - FU_W'(1));
                        ft_wr_data = {cur_start_ff, size_inc, cur_first_ff,
                                      cur_total_in};
                     end
                  end
                  OP_LOOKUP: begin
                     qoff_in     = req_ch.query_offset;
                     scan_idx_in = '0;
                     if ({1'b0, req_ch.query_offset} >= total_ff) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  OP_BASE: begin
                     if (QX_W'(req_ch.query_file) < QX_W'(files_used_ff)) begin
                        res_fidx_in = FILE_IDX_W'(req_ch.query_file);
                        state_in    = S_BASE;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_BASE: begin
            res_status_in = STATUS_OK;
            res_base_in   = ft_start;
            state_in      = S_EMIT;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (cmp_res.ge && cmp_res.lt_end) begin
               local_in    = cmp_res.diff[OFFSET_BITS-1:0];
               first_in    = ft_first;
               low_in      = '0;
               high_in     = ft_total;
               idx_in      = '0;
               col_in      = COL_W'(cmp_res.diff) + COL_W'(1);
               res_fidx_in = FILE_IDX_W'(scan_idx_ff);
               res_base_in = ft_start;
               state_in    = S_BS_RD;
            end else if (FU_W'(scan_idx_ff) == files_used_ff - FU_W'(1)) begin
               state_in = S_EMIT;
            end else begin
               scan_idx_in = scan_idx_ff + FI_W'(1);
               state_in    = S_SCAN_RD;
            end
         end
         S_BS_RD: begin
            if (low_ff < high_ff) begin
               mid_in = mid_w;
               if (line_in_range) begin
                  state_in = S_BS_CHK;
               end else begin
                  // implicit line start zero never lies past the offset
                  idx_in = mid_w;
                  low_in = mid_w + LT_W'(1);
                  col_in = COL_W'(local_ff) + COL_W'(1);
               end
            end else begin
               res_status_in = STATUS_OK;
               res_line_in   = LINE_W'(idx_ff) + LINE_W'(1);
               res_col_in    = col_ff;
               state_in      = S_EMIT;
            end
         end
         S_BS_CHK: begin
            if (!cmp_res.ge) begin
               high_in = mid_ff;
            end else begin
               idx_in = mid_ff;
               low_in = mid_ff + LT_W'(1);
               col_in = COL_W'(cmp_res.diff) + COL_W'(1);
            end
            state_in = S_BS_RD;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         files_used_ff <= '0;
         lines_used_ff <= '0;
         total_ff      <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         files_used_ff <= files_used_in;
         lines_used_ff <= lines_used_in;
         total_ff      <= total_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_start_ff  <= cur_start_in;
      cur_size_ff   <= cur_size_in;
      cur_first_ff  <= cur_first_in;
      cur_total_ff  <= cur_total_in;
      qoff_ff       <= qoff_in;
      scan_idx_ff   <= scan_idx_in;
      local_ff      <= local_in;
      first_ff      <= first_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      idx_ff        <= idx_in;
      mid_ff        <= mid_in;
      col_ff        <= col_in;
      res_status_ff <= res_status_in;
      res_fidx_ff   <= res_fidx_in;
      res_line_ff   <= res_line_in;
      res_col_ff    <= res_col_in;
      res_base_ff   <= res_base_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_fidx_ff   <= res_fidx_ff;
         rsp_line_ff   <= res_line_ff;
         rsp_col_ff    <= res_col_ff;
         rsp_base_ff   <= res_base_ff;
         rsp_ovf_ff    <= overflow_ff;
      end
   end

   // overflow is sticky and sampled when the response is loaded
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.file_index    = rsp_fidx_ff;
   assign rsp_ch.line_number   = rsp_line_ff;
   assign rsp_ch.column_number = rsp_col_ff;
   assign rsp_ch.start_offset  = rsp_base_ff;
   assign rsp_ch.overflow      = rsp_ovf_ff;

   `OTLC_ASSERT_NOW(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_EMIT))
   `OTLC_ASSERT_NOW(a_bs_chk_after_rd, clock, reset, state_ff == S_BS_CHK,
      $past(state_ff == S_BS_RD))
   `OTLC_ASSERT_NEXT(a_orphan_byte_overflow, clock, reset,
      req_ch.valid && req_ch.ready && req_ch.opcode == OP_BYTE && files_used_ff == '0,
      overflow_ff)
   `OTLC_ASSERT_NOW(a_not_found_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff == STATUS_NOT_FOUND,
      rsp_fidx_ff == '0 && rsp_line_ff == '0 && rsp_col_ff == '0 && rsp_base_ff == '0)

endmodule
